[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and types for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FillW  = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [StatW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

[rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [DataW-1:0] item_data;
  logic signed [PrioW-1:0] item_priority;

  modport source (output valid, output op, output item_data, output item_priority,
                  input ready);
  modport sink   (input valid, input op, input item_data, input item_priority,
                  output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic signed [DataW-1:0] head_data;
  logic signed [PrioW-1:0] head_priority;
  logic [FillW-1:0]        fill_level;

  modport source (output valid, output status, output head_data, output head_priority,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input head_data, input head_priority,
                  input fill_level, output ready);
endinterface

[rtl/stable_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// sorted-list priority queue built from a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Holds up to Depth entries (data, priority), smallest priority at the head,
// equal priorities leaving first in, first out. Every cell compares its own
// priority with an incoming entry in parallel, so all cells update at once. A
// new command word is taken every cycle while in_i.ready is high, which drops
// only while a result word is held and out_o.ready is low; the result word
// appears in an output register in the cycle after acceptance. One signed
// compare per cell sets the cycle time. No clearing pass after reset: slots
// are ignored until written; reset clears only the count and result valid.
module stable_sorted_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  // entry count and result register
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  logic [StatW-1:0]        status_q, status_d;
  logic signed [DataW-1:0] head_data_q, head_data_d;
  logic signed [PrioW-1:0] head_prio_q, head_prio_d;
  logic [CntW-1:0]         fill_q;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;

  // chain taps, one per cell
  logic                    le    [Depth];
  logic signed [DataW-1:0] cdata [Depth];
  logic signed [PrioW-1:0] cprio [Depth];

  // a new word goes in whenever the result slot is free or being emptied
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  assign ctrl.insert = accept && (in_i.op == OpInsert) && !full;
  assign ctrl.remove = accept && (in_i.op == OpRemove) && !empty;

  // the cell chain, head at cell 0
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic                    left_le;
    logic signed [DataW-1:0] left_data, right_data;
    logic signed [PrioW-1:0] left_prio, right_prio;

    if (g == 0) begin : g_head
      // nothing ahead of the head: a new entry lands here unless it stays
      assign left_le   = 1'b1;
      assign left_data = in_i.item_data;
      assign left_prio = in_i.item_priority;
    end else begin : g_body
      assign left_le   = le[g-1];
      assign left_data = cdata[g-1];
      assign left_prio = cprio[g-1];
    end

    if (g == Depth - 1) begin : g_tail
      // last slot falls out of range on a remove, contents are don't-care
      assign right_data = cdata[g];
      assign right_prio = cprio[g];
    end else begin : g_mid
      assign right_data = cdata[g+1];
      assign right_prio = cprio[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (count_q > CntW'(g)),
      .new_data_i   (in_i.item_data),
      .new_prio_i   (in_i.item_priority),
      .left_le_i    (left_le),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .le_o         (le[g]),
      .data_o       (cdata[g]),
      .prio_o       (cprio[g])
    );
  end

  // next count and result word
  always_comb begin
    count_d     = count_q;
    status_d    = STATUS_OK;
    head_data_d = '0;
    head_prio_d = '0;
    if (in_i.op == OpInsert) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        count_d     = count_q - CntW'(1);
        head_data_d = cdata[0];
        head_prio_d = cprio[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      head_data_q <= head_data_d;
      head_prio_q <= head_prio_d;
      fill_q      <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.head_data     = head_data_q;
  assign out_o.head_priority = head_prio_q;
  assign out_o.fill_level    = FillW'(fill_q);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // count never runs past the capacity
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above capacity");

  // a dropped insert leaves the queue as it was
  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OpInsert && full) |=> (count_q == $past(count_q)))
    else $error("insert into full queue changed the count");

  // a good remove returns the word that sat at the head
  a_head_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (out_o.head_priority == $past(cprio[0]) &&
                     out_o.head_data == $past(cdata[0])))
    else $error("removed word differs from head cell");

  // insert and remove never both drive the chain
  a_ctrl_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.insert && ctrl.remove))
    else $error("insert and remove together");

endmodule

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compare, keep, take new or shift
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                             clk_i,
  input  spq_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             occ_i,
  input  logic signed [spq_pkg::DataW-1:0] new_data_i,
  input  logic signed [spq_pkg::PrioW-1:0] new_prio_i,
  input  logic                             left_le_i,
  input  logic signed [spq_pkg::DataW-1:0] left_data_i,
  input  logic signed [spq_pkg::PrioW-1:0] left_prio_i,
  input  logic signed [spq_pkg::DataW-1:0] right_data_i,
  input  logic signed [spq_pkg::PrioW-1:0] right_prio_i,
  output logic                             le_o,
  output logic signed [spq_pkg::DataW-1:0] data_o,
  output logic signed [spq_pkg::PrioW-1:0] prio_o
);
  import spq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic signed [PrioW-1:0] prio_q, prio_d;

  // occupied and not after the new entry: stays where it is
  assign le_o = occ_i && (prio_q <= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.insert) begin
      if (!le_o) begin
        if (left_le_i) begin
          data_d = new_data_i;
          prio_d = new_prio_i;
        end else begin
          data_d = left_data_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.remove) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule
